// ===== hdl/emod_pkg.sv =====
// Shared types and codes for the ElGamal modular engine.
// No dependencies; imported by emod_unit and elgamal_modular_engine_core.
package emod_pkg;

    // Item operation codes
    localparam logic [1:0] OP_ENCRYPT = 2'd0;
    localparam logic [1:0] OP_DECRYPT = 2'd1;
    localparam logic [1:0] OP_PUBKEY  = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PRIVATE   = 2'd2;
    localparam logic [1:0] REG_RECIPIENT = 2'd3;

    // Shared arithmetic unit modes
    typedef enum logic
    {
        UNIT_MULMOD = 1'b0,
        UNIT_DIVIDE = 1'b1
    } unit_mode_t;

    // Command from the sequencer to the arithmetic unit
    typedef struct packed
    {
        logic       start;
        unit_mode_t mode;
    } unit_cmd_t;

endpackage

// ===== hdl/emod_unit.sv =====
// Shared bit-serial arithmetic unit: modular multiply (shift-and-add) and
// unsigned restoring division, one bit per cycle. Depends on emod_pkg.
module emod_unit
    import emod_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  unit_cmd_t        cmd,
    input  logic [WIDTH-1:0] modulus,
    input  logic [WIDTH-1:0] opa,
    input  logic [WIDTH-1:0] opb,
    output logic [WIDTH-1:0] result,
    output logic [WIDTH-1:0] quotient,
    output logic             done
);

    localparam int CW = $clog2(WIDTH);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    unit_mode_t       mode_reg;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [WIDTH-1:0] acc_reg;

    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH:0]   sum;
    logic [WIDTH:0]   sum_red;
    logic [WIDTH:0]   shifted;
    logic             ge;
    logic [WIDTH:0]   rem;
    logic [WIDTH-1:0] acc_next;
    logic             qbit;

    // One step: mulmod doubles then adds a, divide shifts in and subtracts
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
        sum     = {1'b0, dbl_red[WIDTH-1:0]} + (b_reg[WIDTH-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
        shifted = {acc_reg, b_reg[WIDTH-1]};
        ge      = (shifted >= {1'b0, a_reg});
        rem     = ge ? shifted - {1'b0, a_reg} : shifted;
        if (mode_reg == UNIT_DIVIDE)
        begin
            acc_next = rem[WIDTH-1:0];
            qbit     = ge;
        end
        else
        begin
            acc_next = sum_red[WIDTH-1:0];
            qbit     = 1'b0;
        end
    end

    // Iteration counter and operand registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= UNIT_MULMOD;
            a_reg    <= '0;
            b_reg    <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WIDTH - 1);
                mode_reg <= cmd.mode;
                a_reg    <= opa;
                b_reg    <= opb;
                acc_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                b_reg   <= {b_reg[WIDTH-2:0], qbit};
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign result   = acc_reg;
    assign quotient = b_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/elgamal_modular_engine_core.sv =====
// ElGamal engine top level: config registers, operation sequencer and
// result register. Depends on emod_pkg and emod_unit.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  cfg      | cfg_we                | cfg_index, cfg_data
//  in       | in_valid / in_stall   | opcode, data_in, cipher_first, ephemeral_key
//  out      | out_valid / out_stall | out_first, out_second, no_inverse
//
// Every modular multiply, reduction and division step runs on one shared
// bit-serial unit; each operation is issued, runs WIDTH steps and is handed back.
// Public key time depends on the set bits of the exponent, encrypt time on the
// set bits of the ephemeral key, and decrypt adds two unit operations plus one
// check state per Euclid round.
// in_stall is high from acceptance until the result transfer completes.
// A held result waits in its register while out_stall is high.
// Reset loads the register defaults and leaves the engine idle.
module elgamal_modular_engine_core
    import emod_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] data_in,
    input  logic [31:0] cipher_first,
    input  logic [31:0] ephemeral_key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_first,
    output logic [31:0] out_second,
    output logic        no_inverse
);

    localparam int CW = $clog2(WIDTH);
    localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_RED_D,
        S_RED_Y,
        S_RED_C,
        S_RED_G,
        S_POW_SQ,
        S_POW_ML,
        S_FMUL,
        S_INV_CHK,
        S_INV_DIV,
        S_INV_MUL,
        S_OUT
    } state_t;

    logic [31:0] modulus_reg;
    logic [31:0] generator_reg;
    logic [31:0] private_reg;
    logic [31:0] recipient_reg;

    state_t           state_reg;
    logic             issued_reg;
    logic             phase_reg;
    logic [1:0]       op_reg;
    logic [WIDTH-1:0] p_reg;
    logic [WIDTH-1:0] d_reg;
    logic [WIDTH-1:0] c1_reg;
    logic [WIDTH-1:0] k_reg;
    logic [WIDTH-1:0] m_reg;
    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] exp_reg;
    logic [CW-1:0]    bit_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] r0_reg;
    logic [WIDTH-1:0] r1_reg;
    logic [WIDTH-1:0] t0_reg;
    logic [WIDTH-1:0] t1_reg;
    logic [WIDTH-1:0] qm_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] first_reg;
    logic [WIDTH-1:0] second_reg;
    logic             flag_reg;

    unit_cmd_t        u_cmd;
    logic [WIDTH-1:0] u_a;
    logic [WIDTH-1:0] u_b;
    logic [WIDTH-1:0] u_res;
    logic [WIDTH-1:0] u_quot;
    logic             u_done;

    logic [WIDTH-1:0] p_cfg;
    logic             busy_op;
    state_t           pow_end;
    logic [WIDTH-1:0] t_new;

    assign p_cfg = WIDTH'(modulus_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= 32'd3;
            generator_reg <= 32'd2;
            private_reg   <= 32'd0;
            recipient_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS:   modulus_reg   <= cfg_data;
                REG_GENERATOR: generator_reg <= cfg_data;
                REG_PRIVATE:   private_reg   <= cfg_data;
                REG_RECIPIENT: recipient_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Unit command and operand selection
    always_comb
    begin
        busy_op = 1'b1;
        u_a     = ONE;
        u_b     = '0;
        case (state_reg)
            S_RED_D:   u_b = d_reg;
            S_RED_Y:   u_b = WIDTH'(recipient_reg);
            S_RED_C:   u_b = c1_reg;
            S_RED_G:   u_b = WIDTH'(generator_reg);
            S_POW_SQ:
            begin
                u_a = r_reg;
                u_b = r_reg;
            end
            S_POW_ML:
            begin
                u_a = base_reg;
                u_b = r_reg;
            end
            S_FMUL:
            begin
                u_a = m_reg;
                u_b = r_reg;
            end
            S_INV_DIV:
            begin
                u_a = r1_reg;
                u_b = r0_reg;
            end
            S_INV_MUL:
            begin
                u_a = qm_reg;
                u_b = t1_reg;
            end
            default:   busy_op = 1'b0;
        endcase
        u_cmd.start = busy_op && !issued_reg;
        u_cmd.mode  = (state_reg == S_INV_DIV) ? UNIT_DIVIDE : UNIT_MULMOD;
    end

    // Where a finished exponentiation goes next
    always_comb
    begin
        if (op_reg == OP_ENCRYPT && !phase_reg)
            pow_end = S_FMUL;
        else if (op_reg == OP_DECRYPT)
            pow_end = S_INV_CHK;
        else
            pow_end = S_OUT;
    end

    // t0 - q*t1 mod p; the true value is below p so wraparound is exact
    assign t_new = t0_reg - u_res + ((t0_reg < u_res) ? p_reg : '0);

    emod_unit #(
        .WIDTH (WIDTH)
    ) u_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (u_cmd),
        .modulus  (p_reg),
        .opa      (u_a),
        .opb      (u_b),
        .result   (u_res),
        .quotient (u_quot),
        .done     (u_done)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            phase_reg  <= 1'b0;
            op_reg     <= OP_ENCRYPT;
            p_reg      <= '0;
            d_reg      <= '0;
            c1_reg     <= '0;
            k_reg      <= '0;
            m_reg      <= '0;
            base_reg   <= '0;
            exp_reg    <= '0;
            bit_reg    <= '0;
            r_reg      <= '0;
            r0_reg     <= '0;
            r1_reg     <= '0;
            t0_reg     <= '0;
            t1_reg     <= '0;
            qm_reg     <= '0;
            rem_reg    <= '0;
            first_reg  <= '0;
            second_reg <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            if (busy_op && !issued_reg)
                issued_reg <= 1'b1;
            if (busy_op && issued_reg && u_done)
                issued_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg     <= opcode;
                        p_reg      <= p_cfg;
                        d_reg      <= WIDTH'(data_in);
                        c1_reg     <= WIDTH'(cipher_first);
                        k_reg      <= WIDTH'(ephemeral_key);
                        phase_reg  <= 1'b0;
                        first_reg  <= '0;
                        second_reg <= '0;
                        flag_reg   <= 1'b0;
                        if (p_cfg < WIDTH'(2) || opcode == OP_UNUSED)
                            state_reg <= S_OUT;
                        else if (opcode == OP_PUBKEY)
                            state_reg <= S_RED_G;
                        else
                            state_reg <= S_RED_D;
                    end
                end
                S_RED_D:
                begin
                    if (issued_reg && u_done)
                    begin
                        m_reg     <= u_res;
                        state_reg <= (op_reg == OP_ENCRYPT) ? S_RED_Y : S_RED_C;
                    end
                end
                S_RED_Y, S_RED_C, S_RED_G:
                begin
                    if (issued_reg && u_done)
                    begin
                        base_reg  <= u_res;
                        exp_reg   <= (state_reg == S_RED_C || op_reg == OP_PUBKEY)
                                     ? WIDTH'(private_reg) : k_reg;
                        r_reg     <= ONE;
                        bit_reg   <= CW'(WIDTH - 1);
                        state_reg <= S_POW_SQ;
                    end
                end
                S_POW_SQ, S_POW_ML:
                begin
                    if (issued_reg && u_done)
                    begin
                        r_reg <= u_res;
                        if (state_reg == S_POW_SQ && exp_reg[WIDTH-1])
                        begin
                            state_reg <= S_POW_ML;
                        end
                        else if (bit_reg != '0)
                        begin
                            bit_reg   <= bit_reg - 1'b1;
                            exp_reg   <= {exp_reg[WIDTH-2:0], 1'b0};
                            state_reg <= S_POW_SQ;
                        end
                        else
                        begin
                            // exponentiation finished
                            if (pow_end == S_OUT)
                                first_reg <= u_res;
                            r0_reg    <= p_reg;
                            r1_reg    <= u_res;
                            t0_reg    <= '0;
                            t1_reg    <= ONE;
                            state_reg <= pow_end;
                        end
                    end
                end
                S_FMUL:
                begin
                    if (issued_reg && u_done)
                    begin
                        second_reg <= u_res;
                        if (op_reg == OP_ENCRYPT)
                        begin
                            phase_reg <= 1'b1;
                            state_reg <= S_RED_G;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_INV_CHK:
                begin
                    if (r1_reg != '0)
                    begin
                        state_reg <= S_INV_DIV;
                    end
                    else if (r0_reg == ONE)
                    begin
                        r_reg     <= t0_reg;
                        state_reg <= S_FMUL;
                    end
                    else
                    begin
                        flag_reg  <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_INV_DIV:
                begin
                    if (issued_reg && u_done)
                    begin
                        // quotient never exceeds p, so q mod p is q or zero
                        qm_reg    <= (u_quot == p_reg) ? '0 : u_quot;
                        rem_reg   <= u_res;
                        state_reg <= S_INV_MUL;
                    end
                end
                S_INV_MUL:
                begin
                    if (issued_reg && u_done)
                    begin
                        t0_reg    <= t1_reg;
                        t1_reg    <= t_new;
                        r0_reg    <= r1_reg;
                        r1_reg    <= rem_reg;
                        state_reg <= S_INV_CHK;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_first  = 32'(first_reg);
    assign out_second = 32'(second_reg);
    assign no_inverse = flag_reg;

    // A result never shows while the input side is open
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result valid while input accepted");

    // A missing inverse always comes with a zero plaintext
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && no_inverse) |-> (second_reg == '0))
        else $error("no_inverse with nonzero plaintext");

    // The first result is always reduced below the modulus
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (p_reg < WIDTH'(2) || first_reg < p_reg))
        else $error("first result not reduced");

    // The unit only finishes while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> (busy_op && issued_reg))
        else $error("unit finished outside an operation");

endmodule
